// ----- rtl/mlft_pkg.sv -----
// Package for the MAC learning forwarding table: shared types and constants.
// No dependencies.
package mlft_pkg;

    localparam int unsigned MacWidth = 48;
    localparam int unsigned CfgWidth = 16;
    localparam int unsigned KindPacket = 0;

    localparam logic [1:0] LearnRefreshed = 2'd0;
    localparam logic [1:0] LearnAdded = 2'd1;
    localparam logic [1:0] LearnFull = 2'd2;
    localparam logic [1:0] LearnNone = 2'd3;

    localparam logic RegLifetime = 1'b0;
    localparam logic RegSweep = 1'b1;

    typedef struct packed {
        logic start_scan;
        logic scan_learn;
        logic scan_lookup;
        logic scan_sweep;
        logic do_write;
        logic tick;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic is_tick;
        logic do_sweep;
    } t_status;

endpackage

// ----- rtl/mlft_ctrl.sv -----
// Controller state machine of the MAC learning forwarding table.
// Depends on mlft_pkg.
module mlft_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_free,
    input  mlft_pkg::t_status i_status,
    output mlft_pkg::t_cmd  o_cmd,
    output logic            o_idle
);
    import mlft_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LEARN  = 5'b00010,
        S_WRITE  = 5'b00100,
        S_LOOKUP = 5'b01000,
        S_SWEEP  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.start_scan = 1'b1;
                    if (!i_status.is_tick) begin
                        n_state = S_LEARN;
                    end else begin
                        o_cmd.tick = 1'b1;
                        if (i_status.do_sweep) begin
                            n_state = S_SWEEP;
                        end else begin
                            o_cmd.finish = 1'b1;
                        end
                    end
                end
            end
            S_LEARN: begin
                o_cmd.scan_learn = 1'b1;
                if (i_status.scan_last) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.do_write = 1'b1;
                o_cmd.start_scan = 1'b1;
                n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.scan_lookup = 1'b1;
                if (i_status.scan_last && i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                o_cmd.scan_sweep = 1'b1;
                if (i_status.scan_last && i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_idle = (r_state == S_IDLE);

    a_write_after_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> $past(r_state) == S_LEARN)
        else $error("write without learn scan");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && r_state != S_IDLE) |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");
    a_one_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.scan_learn, o_cmd.scan_lookup, o_cmd.scan_sweep}))
        else $error("overlapping scans");
endmodule

// ----- rtl/mlft_dp.sv -----
// Datapath of the MAC learning forwarding table: entry memories, scan
// counter, time base and result register. Depends on mlft_pkg.
module mlft_dp #(
    parameter int unsigned TABLE_DEPTH = 128,
    parameter int unsigned PORT_COUNT = 4,
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mlft_pkg::t_cmd               i_cmd,
    output mlft_pkg::t_status            o_status,
    input  logic                         i_opcode,
    input  logic [1:0]                   i_in_port,
    input  logic [mlft_pkg::MacWidth-1:0] i_dst_mac,
    input  logic [mlft_pkg::MacWidth-1:0] i_src_mac,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [mlft_pkg::CfgWidth-1:0] i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_result_kind,
    output logic [3:0]                   o_out_mask,
    output logic                         o_flooded,
    output logic [1:0]                   o_learn_status,
    output logic [7:0]                   o_aged_count
);
    import mlft_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = IW + 1;

    logic [MacWidth-1:0]   r_mem_addr [TABLE_DEPTH];
    logic [1:0]            r_mem_port [TABLE_DEPTH];
    logic [TIME_WIDTH-1:0] r_mem_exp  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    logic [CfgWidth-1:0] r_lifetime, r_interval, r_countdown;
    logic [TIME_WIDTH-1:0] r_time;
    logic [IW-1:0] r_idx, n_idx;
    logic [MacWidth-1:0] r_dst, r_src;
    logic [1:0] r_port;
    logic r_hit, r_have_free, r_done;
    logic [IW-1:0] r_slot, r_free, wr_slot;
    logic [1:0] r_hit_port;
    logic [CW-1:0] r_aged, aged_total;

    logic r_out_valid, r_kind, r_flood;
    logic [3:0] r_mask;
    logic [1:0] r_lstat;
    logic [7:0] r_agedo;

    logic [MacWidth-1:0] r_rd_addr;
    logic [1:0] r_rd_port;
    logic [TIME_WIDTH-1:0] r_rd_exp, diff, new_exp;
    logic rd_valid, scan_any, slot_ok;
    logic learn_found, learn_empty, lookup_hit, aged_hit;
    logic [PORT_COUNT-1:0] flood_mask, all_mask;

    assign rd_valid = r_valid[r_idx];
    assign diff = r_time - r_rd_exp;
    assign new_exp = r_time + TIME_WIDTH'(r_lifetime);
    assign scan_any = i_cmd.scan_learn | i_cmd.scan_lookup | i_cmd.scan_sweep;

    assign learn_found = i_cmd.scan_learn && !r_done && rd_valid && r_rd_addr == r_src;
    assign learn_empty = i_cmd.scan_learn && !r_done && !rd_valid && !r_have_free;
    assign lookup_hit = i_cmd.scan_lookup && !r_done && rd_valid && r_rd_port != r_port
        && r_rd_addr == r_dst;
    assign aged_hit = i_cmd.scan_sweep && rd_valid && diff != '0 && !diff[TIME_WIDTH-1];
    assign aged_total = r_aged + CW'(aged_hit);
    assign slot_ok = r_hit | r_have_free;
    assign wr_slot = r_hit ? r_slot : r_free;

    assign o_status.scan_last = (r_idx == IW'(TABLE_DEPTH - 1)) || r_done;
    assign o_status.is_tick = i_opcode;
    assign o_status.do_sweep = (r_countdown <= CfgWidth'(1));

    assign n_idx = i_cmd.start_scan ? '0
        : ((scan_any && !o_status.scan_last) ? r_idx + IW'(1) : r_idx);

    always_comb begin
        all_mask = '1;
        flood_mask = all_mask;
        if (32'(r_port) < PORT_COUNT) flood_mask = all_mask & ~(PORT_COUNT'(1) << r_port);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && slot_ok) begin
            r_mem_addr[wr_slot] <= r_src;
            r_mem_port[wr_slot] <= r_port;
            r_mem_exp[wr_slot] <= new_exp;
        end
        if (i_cmd.do_write && slot_ok && n_idx == wr_slot) begin
            r_rd_addr <= r_src;
            r_rd_port <= r_port;
            r_rd_exp <= new_exp;
        end else begin
            r_rd_addr <= r_mem_addr[n_idx];
            r_rd_port <= r_mem_port[n_idx];
            r_rd_exp <= r_mem_exp[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan && !i_cmd.do_write) begin
            r_dst <= i_dst_mac;
            r_src <= i_src_mac;
            r_port <= i_in_port;
        end
        if (i_cmd.start_scan) begin
            r_hit <= 1'b0;
            r_have_free <= 1'b0;
            r_aged <= '0;
        end
        if (learn_found) begin
            r_hit <= 1'b1;
            r_slot <= r_idx;
        end else if (learn_empty) begin
            r_have_free <= 1'b1;
            r_free <= r_idx;
        end
        if (lookup_hit) begin
            r_hit <= 1'b1;
            r_hit_port <= r_rd_port;
        end
        if (aged_hit) r_aged <= r_aged + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_time <= '0;
            r_countdown <= '0;
            r_lifetime <= CfgWidth'(10);
            r_interval <= CfgWidth'(5);
            r_idx <= '0;
            r_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == RegLifetime) r_lifetime <= i_cfg_data;
                else if (i_cfg_index == RegSweep) r_interval <= i_cfg_data;
            end
            r_idx <= n_idx;
            if (i_cmd.start_scan) begin
                r_done <= 1'b0;
            end else if (scan_any && !o_status.scan_last) begin
                if (learn_found || lookup_hit) r_done <= 1'b1;
            end
            if (i_cmd.do_write && slot_ok) r_valid[wr_slot] <= 1'b1;
            if (aged_hit) r_valid[r_idx] <= 1'b0;
            if (i_cmd.tick) begin
                r_time <= r_time + TIME_WIDTH'(1);
                if (o_status.do_sweep) r_countdown <= r_interval;
                else r_countdown <= r_countdown - CfgWidth'(1);
            end
            if (i_cmd.finish) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) r_lstat <= r_hit ? LearnRefreshed : (r_have_free ? LearnAdded : LearnFull);
        if (i_cmd.finish) begin
            if (i_cmd.tick || i_cmd.scan_sweep) begin
                r_kind <= 1'b1;
                r_mask <= '0;
                r_flood <= 1'b0;
                if (i_cmd.scan_sweep) begin
                    if (32'(aged_total) > 32'd255) r_agedo <= 8'd255;
                    else r_agedo <= 8'(aged_total);
                end else begin
                    r_agedo <= '0;
                end
            end else begin
                r_kind <= 1'(KindPacket);
                r_agedo <= '0;
                if (r_hit || lookup_hit) begin
                    r_flood <= 1'b0;
                    r_mask <= 4'(16'(1) << (r_hit ? r_hit_port : r_rd_port));
                end else begin
                    r_flood <= 1'b1;
                    r_mask <= 4'(flood_mask);
                end
            end
        end
    end

    logic [1:0] lstat_out;
    assign lstat_out = r_kind ? LearnNone : r_lstat;

    assign o_out_valid = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_out_mask = r_mask;
    assign o_flooded = r_flood;
    assign o_learn_status = lstat_out;
    assign o_aged_count = r_agedo;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_out_valid || i_out_ready)
        else $error("result overwritten");
    a_tick_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick |=> r_time == $past(r_time) + TIME_WIDTH'(1))
        else $error("time did not advance");
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_write && slot_ok) |=> r_valid[$past(wr_slot)])
        else $error("learned entry not valid");
endmodule

// ----- rtl/mac_learning_forwarding_table_unit.sv -----
// Top level of the MAC learning forwarding table.
// Depends on mlft_pkg, mlft_ctrl and mlft_dp.
//
// Input channel (i_in_valid/o_in_ready) carries one item per beat: a packet
// header (source and destination MAC, input port) or a time tick. Each item
// yields exactly one result beat on o_out_valid/i_out_ready.
// A packet scans the table once to learn the source address, writes the
// entry, then scans again to look the destination up, one entry at a time
// through the single read port of the entry store. A tick that sweeps
// scans the table once; one that does not finishes straight from idle.
// The next item is taken once the block is back in idle and the result
// register is free or draining.
// The configuration channel (i_cfg_valid/o_cfg_ready) writes entry
// lifetime (index 0) and sweep interval (index 1); other indexes are
// ignored. It is always ready.
// Reset empties the table, clears time and sweep countdown and loads the
// default register values. A stalled receiver holds the result and blocks
// the scan at its last step until the result register frees.
module mac_learning_forwarding_table_unit #(
    parameter int unsigned TABLE_DEPTH = 128,
    parameter int unsigned PORT_COUNT = 4,
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [1:0]  i_in_port,
    input  logic [47:0] i_dst_mac,
    input  logic [47:0] i_src_mac,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [3:0]  o_out_mask,
    output logic        o_flooded,
    output logic [1:0]  o_learn_status,
    output logic [7:0]  o_aged_count
);
    import mlft_pkg::*;

    t_cmd cmd;
    t_status status;
    logic idle, out_free, cfg_we;

    assign out_free = !o_out_valid || i_out_ready;
    assign o_in_ready = idle && out_free;
    assign o_cfg_ready = 1'b1;
    assign cfg_we = i_cfg_valid && (i_cfg_index[15:1] == '0);

    mlft_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_in_valid && o_in_ready), .i_out_free(out_free),
        .i_status(status), .o_cmd(cmd), .o_idle(idle)
    );

    mlft_dp #(.TABLE_DEPTH(TABLE_DEPTH), .PORT_COUNT(PORT_COUNT), .TIME_WIDTH(TIME_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_opcode(i_opcode), .i_in_port(i_in_port), .i_dst_mac(i_dst_mac),
        .i_src_mac(i_src_mac), .i_cfg_we(cfg_we), .i_cfg_index(i_cfg_index[0]),
        .i_cfg_data(i_cfg_data), .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .o_result_kind(o_result_kind), .o_out_mask(o_out_mask), .o_flooded(o_flooded),
        .o_learn_status(o_learn_status), .o_aged_count(o_aged_count)
    );
endmodule
